// ----- rtl/fvg_pkg.sv -----
// Package with the shared types, constants and divider step function of the FAT geometry block.
`timescale 1ns / 1ps

package fvg_pkg;

  localparam logic [15:0] BOOT_MAGIC       = 16'hAA55;
  localparam logic [31:0] FAT12_LIMIT      = 32'd4085;
  localparam logic [31:0] FAT16_LIMIT      = 32'd65525;
  localparam int          DIR_ENTRY_SHIFT  = 5;  // 32 bytes per directory entry
  localparam logic [40:0] FIRST_CLUSTER    = 41'd2;

  localparam int DIV_STAGES         = 8;
  localparam int DIV_BITS_PER_STAGE = 4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIG  = 2'd1,
    ST_ZERO_DIV = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_FAT12 = 2'd0,
    KIND_FAT16 = 2'd1,
    KIND_FAT32 = 2'd2
  } kind_t;

  // Per-transaction data that travels alongside the dividers.
  typedef struct packed {
    status_t      status;
    logic [7:0]   spc;
    logic [31:0]  tot;
    logic [39:0]  fat_end;
    logic [27:0]  rclus;
    logic [21:0]  rds;
    logic [39:0]  fds;
    logic [40:0]  rprod;
  } side_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [31:0] dq;
  } div_res_t;

  // Several restoring division steps. The dq word shifts dividend bits out at the top
  // and quotient bits in at the bottom.
  function automatic div_res_t div_step(logic [15:0] rem_in, logic [31:0] dq_in,
                                        logic [15:0] dvs);
    logic [16:0] t;
    logic [15:0] rem;
    logic [31:0] dq;
    div_res_t    res;
    rem = rem_in;
    dq  = dq_in;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      t  = {rem, dq[31]};
      dq = {dq[30:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t     = t - {1'b0, dvs};
        dq[0] = 1'b1;
      end
      rem = t[15:0];
    end
    res.rem = rem;
    res.dq  = dq;
    return res;
  endfunction

endpackage

// ----- rtl/fvg_div_pipe.sv -----
// Pipelined 32-bit by 16-bit unsigned divider with a sideband that travels with each transaction.
`timescale 1ns / 1ps

module fvg_div_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_dividend,
  input  logic [15:0]        in_divisor,
  input  fvg_pkg::side_t     in_side,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_quotient,
  output fvg_pkg::side_t     out_side
);
  import fvg_pkg::*;

  logic [DIV_STAGES-1:0] valid_r;
  logic [15:0]           rem_r  [DIV_STAGES];
  logic [31:0]           dq_r   [DIV_STAGES];
  logic [15:0]           dvs_r  [DIV_STAGES];
  side_t                 side_r [DIV_STAGES];

  div_res_t              step     [DIV_STAGES];
  logic [15:0]           dvs_src  [DIV_STAGES];
  side_t                 side_src [DIV_STAGES];
  logic [DIV_STAGES-1:0] vsrc;
  logic [DIV_STAGES:0]   rdy;

  always_comb begin
    step[0]     = div_step(16'd0, in_dividend, in_divisor);
    dvs_src[0]  = in_divisor;
    side_src[0] = in_side;
    vsrc[0]     = in_valid;
    for (int k = 1; k < DIV_STAGES; k++) begin
      step[k]     = div_step(rem_r[k-1], dq_r[k-1], dvs_r[k-1]);
      dvs_src[k]  = dvs_r[k-1];
      side_src[k] = side_r[k-1];
      vsrc[k]     = valid_r[k-1];
    end
  end

  // A stage moves on when it is empty or the stage after it moves on.
  always_comb begin
    rdy[DIV_STAGES] = out_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (rdy[k]) begin
          valid_r[k] <= vsrc[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (rdy[k] && vsrc[k]) begin
        rem_r[k]  <= step[k].rem;
        dq_r[k]   <= step[k].dq;
        dvs_r[k]  <= dvs_src[k];
        side_r[k] <= side_src[k];
      end
    end
  end

  assign in_ready     = rdy[0];
  assign out_valid    = valid_r[DIV_STAGES-1];
  assign out_quotient = dq_r[DIV_STAGES-1];
  assign out_side     = side_r[DIV_STAGES-1];

endmodule

// ----- rtl/fat_volume_geometry.sv -----
// Top level of the FAT volume geometry block: BPB fields in, volume geometry out.
`timescale 1ns / 1ps
// The path from input acceptance to result valid has one setup stage with the
// FAT size multiply, 8 stages of the root directory divider, one stage for the data area
// subtract, 8 stages of the cluster divider and one output register.
// Throughput is one transaction per cycle; each stage stalls only when full and blocked.
// Synchronous active-low reset clears the stage valid bits; data registers are not reset.

module fat_volume_geometry (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_boot_signature,
  input  logic [15:0] in_bytes_per_sector,
  input  logic [7:0]  in_sectors_per_cluster,
  input  logic [15:0] in_reserved_sectors,
  input  logic [7:0]  in_fat_copies,
  input  logic [15:0] in_root_entries,
  input  logic [15:0] in_fat_size_short,
  input  logic [31:0] in_fat_size_long,
  input  logic [15:0] in_total_short,
  input  logic [31:0] in_total_long,
  input  logic [27:0] in_root_cluster,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [1:0]  out_fat_kind,
  output logic [21:0] out_root_dir_size,
  output logic [31:0] out_cluster_count,
  output logic [39:0] out_data_start,
  output logic [40:0] out_root_dir_sector
);
  import fvg_pkg::*;

  // Setup stage.
  logic        s0_valid_r;
  logic        s0_rdy;
  side_t       s0_side_r, s0_side_nxt;
  logic [21:0] s0_num_r, s0_num_nxt;
  logic [15:0] s0_bps_r;

  // Divider 1 output.
  logic        d1_in_ready, d1_out_valid, d1_out_ready;
  logic [31:0] d1_quot;
  side_t       d1_side;

  // Data area stage.
  logic        sa_valid_r;
  logic        sa_rdy;
  side_t       sa_side_r, sa_side_nxt;
  logic [31:0] sa_dvd_r, sa_dvd_nxt;

  // Divider 2 output.
  logic        d2_in_ready, d2_out_valid, d2_out_ready;
  logic [31:0] d2_quot;
  side_t       d2_side;

  // Output stage.
  logic        out_valid_r;
  logic        ob_rdy;
  logic [1:0]  status_r, status_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [21:0] rds_r, rds_nxt;
  logic [31:0] cc_r, cc_nxt;
  logic [39:0] fds_r, fds_nxt;
  logic [40:0] rsec_r, rsec_nxt;

  logic [31:0] fsz;
  logic [39:0] fds_a;

  // ---------------- Setup stage ----------------
  always_comb begin
    fsz = (in_fat_size_short != 16'd0) ? {16'd0, in_fat_size_short} : in_fat_size_long;
    s0_side_nxt         = '0;
    s0_side_nxt.spc     = in_sectors_per_cluster;
    s0_side_nxt.tot     = (in_total_short != 16'd0) ? {16'd0, in_total_short} : in_total_long;
    s0_side_nxt.fat_end = {24'd0, in_reserved_sectors} + ({32'd0, in_fat_copies} * {8'd0, fsz});
    s0_side_nxt.rclus   = in_root_cluster;
    if (in_boot_signature != BOOT_MAGIC) begin
      s0_side_nxt.status = ST_BAD_SIG;
    end else if (in_bytes_per_sector == 16'd0 || in_sectors_per_cluster == 8'd0) begin
      s0_side_nxt.status = ST_ZERO_DIV;
    end else begin
      s0_side_nxt.status = ST_OK;
    end
    // Dividend for the rounded-up division of the root directory byte count by the sector size.
    s0_num_nxt = {1'b0, in_root_entries, {DIR_ENTRY_SHIFT{1'b0}}}
               + {6'd0, in_bytes_per_sector - 16'd1};
  end

  assign s0_rdy   = !s0_valid_r || d1_in_ready;
  assign in_ready = s0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_rdy) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy && in_valid) begin
      s0_side_r <= s0_side_nxt;
      s0_num_r  <= s0_num_nxt;
      s0_bps_r  <= in_bytes_per_sector;
    end
  end

  fvg_div_pipe u_div_rds (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (s0_valid_r),
    .in_ready     (d1_in_ready),
    .in_dividend  ({10'd0, s0_num_r}),
    .in_divisor   (s0_bps_r),
    .in_side      (s0_side_r),
    .out_valid    (d1_out_valid),
    .out_ready    (d1_out_ready),
    .out_quotient (d1_quot),
    .out_side     (d1_side)
  );

  // ---------------- Data area stage ----------------
  always_comb begin
    sa_side_nxt     = d1_side;
    sa_side_nxt.rds = d1_quot[21:0];
    fds_a           = d1_side.fat_end + {18'd0, d1_quot[21:0]};
    sa_side_nxt.fds = fds_a;
    // A data area that would be negative gives zero clusters.
    sa_dvd_nxt = ({8'd0, d1_side.tot} > fds_a) ? (d1_side.tot - fds_a[31:0]) : 32'd0;
    // Cluster number below two wraps modulo 2^41 like the rest of the sum.
    sa_side_nxt.rprod = ({13'd0, d1_side.rclus} - FIRST_CLUSTER) * {33'd0, d1_side.spc};
  end

  assign sa_rdy       = !sa_valid_r || d2_in_ready;
  assign d1_out_ready = sa_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else if (sa_rdy) begin
      sa_valid_r <= d1_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sa_rdy && d1_out_valid) begin
      sa_side_r <= sa_side_nxt;
      sa_dvd_r  <= sa_dvd_nxt;
    end
  end

  fvg_div_pipe u_div_cc (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sa_valid_r),
    .in_ready     (d2_in_ready),
    .in_dividend  (sa_dvd_r),
    .in_divisor   ({8'd0, sa_side_r.spc}),
    .in_side      (sa_side_r),
    .out_valid    (d2_out_valid),
    .out_ready    (d2_out_ready),
    .out_quotient (d2_quot),
    .out_side     (d2_side)
  );

  // ---------------- Output stage ----------------
  always_comb begin
    status_nxt = d2_side.status;
    kind_nxt   = KIND_FAT12;
    rds_nxt    = '0;
    cc_nxt     = '0;
    fds_nxt    = '0;
    rsec_nxt   = '0;
    if (d2_side.status == ST_OK) begin
      if (d2_quot < FAT12_LIMIT) begin
        kind_nxt = KIND_FAT12;
      end else if (d2_quot < FAT16_LIMIT) begin
        kind_nxt = KIND_FAT16;
      end else begin
        kind_nxt = KIND_FAT32;
      end
      rds_nxt = d2_side.rds;
      cc_nxt  = d2_quot;
      fds_nxt = d2_side.fds;
      if (kind_nxt == KIND_FAT32) begin
        rsec_nxt = d2_side.rprod + {1'b0, d2_side.fds};
      end else begin
        rsec_nxt = {1'b0, d2_side.fat_end};
      end
    end
  end

  assign ob_rdy       = !out_valid_r || out_ready;
  assign d2_out_ready = ob_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ob_rdy) begin
      out_valid_r <= d2_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_rdy && d2_out_valid) begin
      status_r <= status_nxt;
      kind_r   <= kind_nxt;
      rds_r    <= rds_nxt;
      cc_r     <= cc_nxt;
      fds_r    <= fds_nxt;
      rsec_r   <= rsec_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_fat_kind        = kind_r;
  assign out_root_dir_size   = rds_r;
  assign out_cluster_count   = cc_r;
  assign out_data_start      = fds_r;
  assign out_root_dir_sector = rsec_r;

endmodule
